[hdl/pscnt_pkg.sv]
`default_nettype none
package pscnt_pkg;

	localparam int FIRST_DEPTH_DEF  = 1024;
	localparam int SECOND_DEPTH_DEF = 1024;
	localparam int TABLE_SLOTS_DEF  = 2048;

	localparam int LEN_W     = 11;
	localparam int CNT_W     = 11;
	localparam int PAIR_W    = 21;
	localparam int KEY_W     = 32;
	localparam int IDX_W     = 10;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LEN  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LEN = 1'b1;

	localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
	localparam logic [PAIR_W-1:0] PAIR_MAX  = '1;
	localparam logic [KEY_W-1:0]  HASH_MULT = 32'h9E37_79B1;

	typedef enum logic [1:0] {
		OP_LOAD_FIRST,
		OP_LOAD_SECOND,
		OP_ADD_DELTA,
		OP_COUNT
	} opcode_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [IDX_W-1:0]   index;
		logic signed [31:0] value;
	} in_beat_t;

	typedef struct packed {
		logic [PAIR_W-1:0] pair_count;
		logic              status;
	} out_beat_t;

	// one table slot
	typedef struct packed {
		logic             valid;
		logic [CNT_W-1:0] count;
		logic [KEY_W-1:0] key;
	} tbl_word_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_DAT,
		ST_ADD_UP,
		ST_CNT_RD,
		ST_CNT_DAT,
		ST_HASH_A,
		ST_HASH_B,
		ST_HASH_C,
		ST_PROBE_RD,
		ST_PROBE_CHK,
		ST_REM_RD,
		ST_REM_DAT,
		ST_REM_END,
		ST_FIN
	} state_t;

	// table operation in progress
	typedef enum logic [1:0] {
		SUB_UP,
		SUB_DOWN,
		SUB_OF,
		SUB_REM
	} sub_t;

endpackage
`default_nettype wire

[hdl/pair_sum_count_table.sv]
// Channel   Signals                      Handshake
// command   start, cmd                   taken when start && !busy
// result    done, result                 one-cycle strobe, no back-pressure
// config    cfg_we, cfg_addr, cfg_wdata  written on any edge with cfg_we
//
// One command at a time. Load first writes the list and finishes. Load second
// hashes the value, then probes the table slot by slot for it. Add delta:
// decrement, optional removal, then increment; a removal scans the slots past
// the hole. Count: one hash and probe sequence per element.
// The single read port of the slot memory and the two-stage hash pace each step.
// After reset busy stays high while the table is cleared.
// Results cannot be stalled.
`default_nettype none
module pair_sum_count_table #(
	parameter int FIRST_DEPTH  = pscnt_pkg::FIRST_DEPTH_DEF,
	parameter int SECOND_DEPTH = pscnt_pkg::SECOND_DEPTH_DEF,
	parameter int TABLE_SLOTS  = pscnt_pkg::TABLE_SLOTS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire pscnt_pkg::in_beat_t        cmd,
	output logic                            done,
	output pscnt_pkg::out_beat_t            result,
	input  wire logic                       cfg_we,
	input  wire logic [pscnt_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  wire logic [pscnt_pkg::LEN_W-1:0]     cfg_wdata
);
	import pscnt_pkg::*;

	localparam int LIST_D = FIRST_DEPTH + SECOND_DEPTH;
	localparam int LAW    = $clog2(LIST_D);
	localparam int SW     = $clog2(TABLE_SLOTS);
	localparam int NW     = SW + 1;
	localparam int XW     = 17;

	localparam logic [XW-1:0]  FD_X      = XW'(FIRST_DEPTH);
	localparam logic [XW-1:0]  SD_X      = XW'(SECOND_DEPTH);
	localparam logic [LAW-1:0] SEC_BASE  = LAW'(FIRST_DEPTH);
	localparam logic [SW-1:0]  SLOT_LAST = SW'(TABLE_SLOTS - 1);
	localparam logic [NW-1:0]  SLOTS_N   = NW'(TABLE_SLOTS);

	// control
	state_t            state_q, state_d;
	sub_t              sub_q, sub_d;
	logic [SW-1:0]     clr_q;
	logic [LEN_W-1:0]  first_len_q, second_len_q;

	// datapath
	in_beat_t          cmd_q;
	logic [KEY_W-1:0]  key_q, hkey_q, nv_q;
	logic [SW-1:0]     slot_q, hole_q, j_q;
	logic [NW-1:0]     n_q;
	tbl_word_t         jword_q;
	logic [XW-1:0]     i_q, len_q;
	logic [PAIR_W-1:0] pairs_q;
	logic              status_q;

	// memories
	logic              list_we;
	logic [LAW-1:0]    list_waddr, list_raddr;
	logic [KEY_W-1:0]  list_wdata, list_rd;
	logic              tbl_we;
	logic [SW-1:0]     tbl_waddr, tbl_raddr;
	tbl_word_t         tbl_wdata, tbl_rd;
	logic [SW-1:0]     hash_slot;

	pscnt_ram #(.W(KEY_W), .D(LIST_D)) u_list (
		.clk   (clk),
		.we    (list_we),
		.waddr (list_waddr),
		.wdata (list_wdata),
		.raddr (list_raddr),
		.rdata (list_rd)
	);

	pscnt_ram #(.W($bits(tbl_word_t)), .D(TABLE_SLOTS)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rd)
	);

	pscnt_hash #(.TABLE_SLOTS(TABLE_SLOTS)) u_hash (
		.clk  (clk),
		.key  (hkey_q),
		.slot (hash_slot)
	);

	// lengths clamped to the list depths
	logic [XW-1:0] fl_x, sl_x, eff_first, eff_second, idx_x;
	logic          oob;

	assign fl_x       = XW'(first_len_q);
	assign sl_x       = XW'(second_len_q);
	assign eff_first  = (fl_x > FD_X) ? FD_X : fl_x;
	assign eff_second = (sl_x > SD_X) ? SD_X : sl_x;
	assign idx_x      = XW'(cmd.index);
	assign oob        = (cmd.opcode == OP_LOAD_FIRST) ? (idx_x >= eff_first)
	                                                  : (idx_x >= eff_second);

	// probe outcome
	logic              hit, miss_end, resolved;
	logic [CNT_W-1:0]  cnt_up, cnt_dn;
	logic [PAIR_W:0]   pair_sum;
	logic [PAIR_W-1:0] pair_next;
	logic              stays;

	assign hit      = tbl_rd.valid && (tbl_rd.key == key_q);
	assign miss_end = !tbl_rd.valid || (n_q == SLOTS_N - NW'(1));
	assign resolved = hit || miss_end;
	assign cnt_up   = (tbl_rd.count == COUNT_MAX) ? tbl_rd.count : tbl_rd.count + CNT_W'(1);
	assign cnt_dn   = tbl_rd.count - CNT_W'(tbl_rd.count != '0);
	assign pair_sum = (PAIR_W+1)'(pairs_q) + (PAIR_W+1)'(hit ? tbl_rd.count : '0);
	assign pair_next = (pair_sum > (PAIR_W+1)'(PAIR_MAX)) ? PAIR_MAX : pair_sum[PAIR_W-1:0];

	// backward-shift delete: entry at j stays if its home lies in (hole, j]
	assign stays = (hole_q <= j_q) ? ((hole_q < hash_slot) && (hash_slot <= j_q))
	                               : ((hole_q < hash_slot) || (hash_slot <= j_q));

	function automatic logic [SW-1:0] nxt(input logic [SW-1:0] s);
		nxt = (s == SLOT_LAST) ? '0 : s + SW'(1);
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		sub_d   = sub_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == SLOT_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					unique case (cmd.opcode)
						OP_LOAD_FIRST: state_d = ST_FIN;
						OP_LOAD_SECOND: begin
							state_d = oob ? ST_FIN : ST_HASH_A;
							sub_d   = SUB_UP;
						end
						OP_ADD_DELTA: begin
							state_d = oob ? ST_FIN : ST_ADD_RD;
							sub_d   = SUB_DOWN;
						end
						OP_COUNT: begin
							state_d = (eff_first == '0) ? ST_FIN : ST_CNT_RD;
							sub_d   = SUB_OF;
						end
					endcase
				end
			end
			ST_ADD_RD:  state_d = ST_ADD_DAT;
			ST_ADD_DAT: state_d = ST_HASH_A;
			ST_ADD_UP: begin
				state_d = ST_HASH_A;
				sub_d   = SUB_UP;
			end
			ST_CNT_RD:  state_d = ST_CNT_DAT;
			ST_CNT_DAT: state_d = ST_HASH_A;
			ST_HASH_A:  state_d = ST_HASH_B;
			ST_HASH_B:  state_d = ST_HASH_C;
			ST_HASH_C:  state_d = (sub_q == SUB_REM) ? ST_REM_RD : ST_PROBE_RD;
			ST_PROBE_RD: state_d = ST_PROBE_CHK;
			ST_PROBE_CHK: begin
				if (!resolved) begin
					state_d = ST_PROBE_RD;
				end else begin
					unique case (sub_q)
						SUB_UP: state_d = ST_FIN;
						SUB_DOWN: begin
							if (hit && cnt_dn == '0) begin
								state_d = ST_REM_RD;
								sub_d   = SUB_REM;
							end else begin
								state_d = ST_ADD_UP;
							end
						end
						SUB_OF: state_d = (i_q + XW'(1) == len_q) ? ST_FIN : ST_CNT_RD;
						SUB_REM: state_d = ST_FIN;
					endcase
				end
			end
			ST_REM_RD:  state_d = (n_q == SLOTS_N) ? ST_REM_END : ST_REM_DAT;
			ST_REM_DAT: state_d = tbl_rd.valid ? ST_HASH_A : ST_REM_END;
			ST_REM_END: state_d = ST_ADD_UP;
			ST_FIN:     state_d = ST_IDLE;
		endcase
	end

	// memory ports
	always_comb begin
		list_we    = 1'b0;
		list_waddr = LAW'(cmd.index);
		list_wdata = cmd.value;
		list_raddr = LAW'(i_q);
		tbl_we     = 1'b0;
		tbl_waddr  = slot_q;
		tbl_wdata  = '0;
		tbl_raddr  = (state_q == ST_REM_RD) ? nxt(j_q) : slot_q;
		priority case (state_q)
			ST_CLEAR: begin
				tbl_we    = 1'b1;
				tbl_waddr = clr_q;
			end
			ST_IDLE: begin
				if (start && !oob) begin
					if (cmd.opcode == OP_LOAD_FIRST) begin
						list_we = 1'b1;
					end else if (cmd.opcode == OP_LOAD_SECOND) begin
						list_we    = 1'b1;
						list_waddr = SEC_BASE + LAW'(cmd.index);
					end
				end
			end
			ST_ADD_RD: list_raddr = SEC_BASE + LAW'(cmd_q.index);
			ST_ADD_UP: begin
				list_we    = 1'b1;
				list_waddr = SEC_BASE + LAW'(cmd_q.index);
				list_wdata = nv_q;
			end
			ST_PROBE_CHK: begin
				if (sub_q == SUB_UP && hit) begin
					tbl_we    = 1'b1;
					tbl_wdata = '{valid: 1'b1, count: cnt_up, key: key_q};
				end else if (sub_q == SUB_UP && !tbl_rd.valid) begin
					tbl_we    = 1'b1;
					tbl_wdata = '{valid: 1'b1, count: CNT_W'(1), key: key_q};
				end else if (sub_q == SUB_DOWN && hit && cnt_dn != '0) begin
					tbl_we    = 1'b1;
					tbl_wdata = '{valid: 1'b1, count: cnt_dn, key: key_q};
				end
			end
			ST_HASH_C: begin
				if (sub_q == SUB_REM && !stays) begin
					tbl_we    = 1'b1;
					tbl_waddr = hole_q;
					tbl_wdata = jword_q;
				end
			end
			ST_REM_END: begin
				tbl_we    = 1'b1;
				tbl_waddr = hole_q;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			sub_q        <= SUB_UP;
			clr_q        <= '0;
			first_len_q  <= '0;
			second_len_q <= '0;
		end else begin
			state_q <= state_d;
			sub_q   <= sub_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + SW'(1);
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_FIRST_LEN:  first_len_q  <= cfg_wdata;
					CFG_SECOND_LEN: second_len_q <= cfg_wdata;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_q    <= cmd;
					pairs_q  <= '0;
					status_q <= (cmd.opcode != OP_COUNT) && oob;
					i_q      <= '0;
					len_q    <= eff_first;
					key_q    <= cmd.value;
					hkey_q   <= cmd.value;
				end
			end
			ST_ADD_DAT: begin
				key_q  <= list_rd;
				hkey_q <= list_rd;
				nv_q   <= list_rd + cmd_q.value;
			end
			ST_ADD_UP: begin
				key_q  <= nv_q;
				hkey_q <= nv_q;
			end
			ST_CNT_DAT: begin
				key_q  <= cmd_q.value - list_rd;
				hkey_q <= cmd_q.value - list_rd;
			end
			ST_HASH_C: begin
				if (sub_q != SUB_REM) begin
					slot_q <= hash_slot;
					n_q    <= '0;
				end else if (!stays) begin
					hole_q <= j_q;
				end
			end
			ST_PROBE_CHK: begin
				if (!resolved) begin
					slot_q <= nxt(slot_q);
					n_q    <= n_q + NW'(1);
				end else if (sub_q == SUB_DOWN) begin
					hole_q <= slot_q;
					j_q    <= slot_q;
					n_q    <= NW'(1);
				end else if (sub_q == SUB_OF) begin
					pairs_q <= pair_next;
					i_q     <= i_q + XW'(1);
				end
			end
			ST_REM_RD: begin
				if (n_q != SLOTS_N) begin
					j_q <= nxt(j_q);
					n_q <= n_q + NW'(1);
				end
			end
			ST_REM_DAT: begin
				jword_q <= tbl_rd;
				hkey_q  <= tbl_rd.key;
			end
			default: begin
			end
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = (state_q == ST_FIN);
	assign result = '{pair_count: pairs_q, status: status_q};

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result strobe outside a command");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy)
		else $error("block not idle after result");
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status) |-> (result.pair_count == '0))
		else $error("flagged result carries a pair count");
	a_tbl_wr_busy: assert property (@(posedge clk) disable iff (!arst_n) tbl_we |-> busy)
		else $error("table write while idle");

endmodule
`default_nettype wire

[hdl/pscnt_ram.sv]
`default_nettype none
module pscnt_ram #(
	parameter int W = 32,
	parameter int D = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                we,
	input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  wire logic [W-1:0]                        wdata,
	input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic      [W-1:0]                        rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[hdl/pscnt_hash.sv]
`default_nettype none
module pscnt_hash #(
	parameter int TABLE_SLOTS = 2048
) (
	input  wire logic                           clk,
	input  wire logic [31:0]                    key,
	output logic      [$clog2(TABLE_SLOTS)-1:0] slot
);
	import pscnt_pkg::*;

	localparam int SW = $clog2(TABLE_SLOTS);
	localparam int PW = KEY_W + SW;

	logic [KEY_W-1:0] prod_s1;
	logic [KEY_W-1:0] mix;
	logic [PW-1:0]    scaled;

	assign mix    = prod_s1 ^ (prod_s1 >> 16);
	// range reduction: high part of mix * slots
	assign scaled = PW'(mix) * PW'(TABLE_SLOTS);

	always_ff @(posedge clk) begin
		prod_s1 <= key * HASH_MULT;
		slot    <= scaled[PW-1:KEY_W];
	end
endmodule
`default_nettype wire

[tb/pair_sum_count_checker.sv]
`default_nettype none
module pair_sum_count_checker
	import pscnt_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 busy,
	input  wire in_beat_t             cmd,
	input  wire logic                 done,
	input  wire out_beat_t            result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_addr,
	input  wire logic [LEN_W-1:0]     cfg_wdata,
	output int                        fail_count,
	output int                        results_waiting,
	output int                        results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [31:0]       first_vals [FIRST_DEPTH_DEF];
	logic [31:0]       second_vals [SECOND_DEPTH_DEF];
	int unsigned       value_tally [bit [31:0]];
	logic [LEN_W-1:0]  first_len;
	logic [LEN_W-1:0]  second_len;
	out_beat_t         pending_results [$];

	task automatic report(input string what);
		$display("%0t ns: %s", $realtime, what);
		fail_count++;
	endtask

	function automatic void tally_up(input bit [31:0] k);
		if (value_tally.exists(k)) begin
			if (value_tally[k] < COUNT_MAX)
				value_tally[k]++;
		end else if (value_tally.num() < TABLE_SLOTS_DEF) begin
			value_tally[k] = 1;
		end
	endfunction

	function automatic void tally_down(input bit [31:0] k);
		if (value_tally.exists(k)) begin
			value_tally[k]--;
			if (value_tally[k] == 0)
				value_tally.delete(k);
		end
	endfunction

	function automatic out_beat_t pair_sum_outcome(input in_beat_t c);
		out_beat_t   r;
		int unsigned n;
		bit [31:0]   pairs;
		bit [31:0]   k;
		bit [31:0]   old;
		r = '0;
		case (c.opcode)
			OP_LOAD_FIRST: begin
				if (c.index >= first_len)
					r.status = 1'b1;
				else
					first_vals[c.index] = c.value;
			end
			OP_LOAD_SECOND, OP_ADD_DELTA: begin
				if (c.index >= second_len) begin
					r.status = 1'b1;
				end else if (c.opcode == OP_LOAD_SECOND) begin
					second_vals[c.index] = c.value;
					tally_up(c.value);
				end else begin
					old = second_vals[c.index];
					tally_down(old);
					second_vals[c.index] = old + c.value;
					tally_up(old + c.value);
				end
			end
			default: begin
				n = (first_len > FIRST_DEPTH_DEF) ? FIRST_DEPTH_DEF : first_len;
				pairs = 0;
				for (int i = 0; i < n; i++) begin
					k = c.value - first_vals[i];
					if (value_tally.exists(k))
						pairs += value_tally[k];
					if (pairs > PAIR_MAX)
						pairs = PAIR_MAX;
				end
				r.pair_count = pairs[PAIR_W-1:0];
			end
		endcase
		return r;
	endfunction

	initial begin
		fail_count = 0;
		results_checked = 0;
		results_waiting = 0;
		first_len = '0;
		second_len = '0;
	end

	// results first, so a beat taken on the same edge queues behind them
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					report("result with nothing outstanding");
				end else begin
					want = pending_results.pop_front();
					results_checked++;
					if (result.pair_count !== want.pair_count)
						report($sformatf("pair_count %0d, want %0d",
							result.pair_count, want.pair_count));
					if (result.status !== want.status)
						report($sformatf("status %0b, want %0b",
							result.status, want.status));
				end
			end
			if (start && !busy)
				pending_results.push_back(pair_sum_outcome(cmd));
			results_waiting = pending_results.size();
			if (cfg_we) begin
				if (cfg_addr == CFG_FIRST_LEN)
					first_len = cfg_wdata;
				else
					second_len = cfg_wdata;
			end
		end
	end
endmodule
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pscnt_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	in_beat_t             cmd;
	logic                 done;
	out_beat_t            result;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [LEN_W-1:0]     cfg_wdata;
	int                   fail_count;
	int                   results_waiting;
	int                   results_checked;

	// stimulus-side bookkeeping: which list slots hold a loaded value, so
	// that no unwritten element is ever read by a count or an add
	bit                   first_loaded [FIRST_DEPTH_DEF];
	bit                   second_loaded [SECOND_DEPTH_DEF];
	int unsigned          first_span;
	int unsigned          second_span;
	bit                   no_gaps;
	int unsigned          op_tally [4];

	pair_sum_count_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	pair_sum_count_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.cmd             (cmd),
		.done            (done),
		.result          (result),
		.cfg_we          (cfg_we),
		.cfg_addr        (cfg_addr),
		.cfg_wdata       (cfg_wdata),
		.fail_count      (fail_count),
		.results_waiting (results_waiting),
		.results_checked (results_checked)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// no count over 1024 elements is ever issued, so this timeout leaves a wide
	// margin over the table clear and all beats
	initial begin
		#20ms;
		$display("pair_sum_count_table: mismatch");
		$finish;
	end

	// random sender gap, about 13 in 100 beats, skipped in the quiet stretch
	task automatic maybe_idle();
		if (!no_gaps && $urandom_range(99) < 13) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// drive one beat; start stays high afterwards so back-to-back beats work
	task automatic send(input opcode_t op, input logic [IDX_W-1:0] idx,
			input logic [31:0] val);
		maybe_idle();
		start <= 1'b1;
		cmd <= '{opcode: op, index: idx, value: val};
		do
			@(posedge clk);
		while (busy);
		op_tally[op]++;
		if (op == OP_LOAD_FIRST && idx < first_span)
			first_loaded[idx] = 1'b1;
		if (op == OP_LOAD_SECOND && idx < second_span)
			second_loaded[idx] = 1'b1;
	endtask

	// park the command side until every result is in and the block is idle
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (results_waiting != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write enable is left high; the caller drops it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] addr,
			input logic [LEN_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	task automatic set_lengths(input logic [LEN_W-1:0] f, input logic [LEN_W-1:0] s);
		drain();
		write_reg(CFG_FIRST_LEN, f);
		write_reg(CFG_SECOND_LEN, s);
		cfg_we <= 1'b0;
		first_span = (f > FIRST_DEPTH_DEF) ? FIRST_DEPTH_DEF : f;
		second_span = (s > SECOND_DEPTH_DEF) ? SECOND_DEPTH_DEF : s;
	endtask

	// values from a small pool so pair sums actually hit, plus wrap extremes
	// and an occasional fully random word
	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'hFFFF_FFFF;
			3:       return $urandom();
			default: return $urandom_range(6);
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] pick_index(input int unsigned span);
		if (span > 0 && $urandom_range(9) < 8)
			return IDX_W'($urandom_range(span - 1));
		return IDX_W'($urandom_range(1023));
	endfunction

	// one well-formed random beat; an add at an unloaded slot becomes a load,
	// a count over unloaded elements becomes a load of the first gap
	task automatic random_beat();
		opcode_t          op;
		logic [IDX_W-1:0] idx;
		logic [31:0]      val;
		int               gap;
		op = opcode_t'($urandom_range(3));
		val = pick_value();
		gap = -1;
		if (op == OP_LOAD_FIRST)
			idx = pick_index(first_span);
		else
			idx = pick_index(second_span);
		if (op == OP_ADD_DELTA && idx < second_span && !second_loaded[idx])
			op = OP_LOAD_SECOND;
		if (op == OP_COUNT) begin
			for (int i = first_span - 1; i >= 0; i--)
				if (!first_loaded[i])
					gap = i;
			if (gap >= 0) begin
				op = OP_LOAD_FIRST;
				idx = IDX_W'(gap);
			end else if ($urandom_range(1)) begin
				// a total that is likely to have partners
				val = pick_value() + pick_value();
			end
		end
		send(op, idx, val);
	endtask

	initial begin
		logic [LEN_W-1:0] f_cfg [7];
		logic [LEN_W-1:0] s_cfg [7];
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_addr = CFG_FIRST_LEN;
		cfg_wdata = '0;
		no_gaps = 1'b0;
		first_span = 0;
		second_span = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);

		// reset lengths are zero: every indexed op is out of range, count is 0
		send(OP_LOAD_FIRST, 10'd0, 32'h1);
		send(OP_LOAD_SECOND, 10'h3FF, 32'hFFFF_FFFF);
		send(OP_ADD_DELTA, 10'd0, 32'h1);
		send(OP_COUNT, 10'h3FF, 32'h7FFF_FFFF);

		set_lengths(11'd2, 11'd2);
		send(OP_LOAD_FIRST, 10'd0, 32'h8000_0000);
		send(OP_LOAD_FIRST, 10'd1, 32'h7FFF_FFFF);
		send(OP_LOAD_FIRST, 10'd2, 32'h5);          // just past the length
		send(OP_LOAD_SECOND, 10'd0, 32'h1);
		send(OP_LOAD_SECOND, 10'd1, 32'h7FFF_FFFF);
		send(OP_COUNT, 10'd0, 32'h8000_0001);       // total minus element wraps
		send(OP_LOAD_SECOND, 10'd0, 32'h1);         // reload counts the value twice
		send(OP_ADD_DELTA, 10'd1, 32'h1);           // element wraps to the minimum
		send(OP_ADD_DELTA, 10'd0, 32'h0);           // same key down then up
		send(OP_COUNT, 10'd0, 32'h0000_0001);
		send(OP_ADD_DELTA, 10'd0, 32'hFFFF_FFFF);   // count drops, entry kept
		send(OP_COUNT, 10'd0, 32'hFFFF_FFFF);
		send(OP_ADD_DELTA, 10'd2, 32'h1);           // out of range add
		send(OP_COUNT, 10'h2AA, 32'h8000_0000);

		// length settings per phase, reset value and upper extremes among them;
		// 2047 acts as the full depth
		f_cfg = '{11'd8, 11'd3, 11'd2047, 11'd1, 11'd12, 11'd0, 11'd1024};
		s_cfg = '{11'd8, 11'd16, 11'd2047, 11'd1, 11'd6, 11'd1024, 11'd0};
		for (int p = 0; p < 7; p++) begin
			set_lengths(f_cfg[p], s_cfg[p]);
			no_gaps = (p == 1);
			for (int n = 0; n < 82; n++) begin
				random_beat();
				if (p == 4 && n == 40) begin
					// let the block go fully empty mid-phase
					drain();
				end
			end
		end
		no_gaps = 1'b0;

		start <= 1'b0;
		@(posedge clk);
		while (results_waiting != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("covered %0d first loads, %0d second loads, %0d adds, %0d counts",
			op_tally[OP_LOAD_FIRST], op_tally[OP_LOAD_SECOND],
			op_tally[OP_ADD_DELTA], op_tally[OP_COUNT]);
		$display("%0d results checked over 9 length settings", results_checked);
		if (fail_count == 0 && results_waiting == 0) begin
			$display("pair_sum_count_table: match");
		end else begin
			$display("pair_sum_count_table: mismatch");
		end
		$finish;
	end
endmodule
`default_nettype wire

[files.f]
hdl/pscnt_pkg.sv
hdl/pscnt_ram.sv
hdl/pscnt_hash.sv
hdl/pair_sum_count_table.sv
tb/pair_sum_count_checker.sv
tb/tb_top.sv
